@@ design/bpc_pkg.sv @@
package bpc_pkg;

	localparam int unsigned ARITH_WIDTH = 32;
	localparam int unsigned CNT_W = $clog2(ARITH_WIDTH);

	typedef logic [ARITH_WIDTH-1:0] word_t;

	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_COEFF_A = 2'd0;
	localparam cfg_index_t CFG_COEFF_B = 2'd1;
	localparam cfg_index_t CFG_COEFF_C = 2'd2;
	localparam cfg_index_t CFG_OSS     = 2'd3;

	localparam logic MODE_TEMP  = 1'b0;
	localparam logic MODE_PRESS = 1'b1;

	localparam word_t K_4000  = word_t'(4000);
	localparam word_t K_3038  = word_t'(3038);
	localparam word_t K_M7357 = word_t'(-7357);
	localparam word_t K_3791  = word_t'(3791);
	localparam word_t K_32768 = word_t'(32768);
	localparam logic [16:0] K_50000 = 17'd50000;

	// Arithmetic right shift of a datapath word by n bits.
	function automatic word_t sra(input word_t x, input logic [4:0] n);
		return word_t'($signed(x) >>> n);
	endfunction

	function automatic word_t sx16(input logic [15:0] v);
		return {{(ARITH_WIDTH-16){v[15]}}, v};
	endfunction

	function automatic word_t zx16(input logic [15:0] v);
		return {{(ARITH_WIDTH-16){1'b0}}, v};
	endfunction

	function automatic word_t mag(input word_t x);
		return x[ARITH_WIDTH-1] ? word_t'(-x) : x;
	endfunction

endpackage

@@ design/bpc_mul.sv @@
module bpc_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bpc_pkg::word_t a,
	input  bpc_pkg::word_t b,
	output logic           done,
	output bpc_pkg::word_t p
);

	bpc_pkg::word_t a_q, b_q, acc_q;
	logic [bpc_pkg::CNT_W-1:0] cnt_q;
	logic busy_q, done_q;

	// One multiplier bit per cycle; only the low word of the product is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {bpc_pkg::CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

@@ design/bpc_div.sv @@
module bpc_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bpc_pkg::word_t n,
	input  bpc_pkg::word_t d,
	output logic           done,
	output bpc_pkg::word_t q
);

	bpc_pkg::word_t rem_q, quo_q, den_q;
	logic [bpc_pkg::CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [bpc_pkg::ARITH_WIDTH:0] shifted, trial;

	// Restoring division, one quotient bit per cycle.
	assign shifted = {rem_q, quo_q[bpc_pkg::ARITH_WIDTH-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {bpc_pkg::CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= n;
			den_q <= d;
		end else if (busy_q) begin
			if (!trial[bpc_pkg::ARITH_WIDTH]) begin
				rem_q <= trial[bpc_pkg::ARITH_WIDTH-1:0];
				quo_q <= {quo_q[bpc_pkg::ARITH_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[bpc_pkg::ARITH_WIDTH-1:0];
				quo_q <= {quo_q[bpc_pkg::ARITH_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign q    = quo_q;

endmodule

@@ design/barometric_pressure_compensation.sv @@
// Temperature item: one serial multiply and one divide from accept to result.
// Pressure item: ten serial multiplies and one divide.
// One item is worked on at a time; the next is taken once the result is in the output register.
// Reset (arst_n low, asynchronous) clears the coefficients, sets oversampling to 3,
// clears the stored B5 and empties the output register.
module barometric_pressure_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [23:0] raw_reading,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [31:0] value,
	output logic        divide_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	// The sequencer walks the compensation formula one operation per state.
	// Each multiply or divide state launches the shared serial multiplier or divider on entry
	// (op_busy_q low) and captures the result when the unit signals done.
	typedef enum logic [4:0] {
		S_IDLE, S_T_X1, S_T_CHK, S_T_DIV,
		S_P_SQ, S_P_X1, S_P_X2, S_P_B3, S_P_X1B, S_P_X2B, S_P_B4, S_P_B7,
		S_P_DIV, S_P_F1, S_P_F2, S_P_F3, S_DONE
	} state_t;

	state_t state_q;
	logic op_busy_q;

	logic [63:0] coeff_a_q, coeff_b_q;
	logic [31:0] coeff_c_q;
	logic [1:0]  oss_q;
	bpc_pkg::word_t b5_q;

	logic        mode_q;
	logic [23:0] raw_q;
	bpc_pkg::word_t x1_q, x3_q, sq_q, na_q, b3_q, b4_q, b7_q, p_q;
	bpc_pkg::word_t res_val_q;
	logic        res_err_q;

	logic        out_valid_q, kind_q, err_q;
	logic [31:0] value_q;

	// Coefficients, unpacked.
	bpc_pkg::word_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = bpc_pkg::sx16(coeff_a_q[63:48]);
	assign ac2 = bpc_pkg::sx16(coeff_a_q[47:32]);
	assign ac3 = bpc_pkg::sx16(coeff_a_q[31:16]);
	assign ac4 = bpc_pkg::zx16(coeff_a_q[15:0]);
	assign ac5 = bpc_pkg::zx16(coeff_b_q[63:48]);
	assign ac6 = bpc_pkg::zx16(coeff_b_q[47:32]);
	assign b1  = bpc_pkg::sx16(coeff_b_q[31:16]);
	assign b2  = bpc_pkg::sx16(coeff_b_q[15:0]);
	assign mc  = bpc_pkg::sx16(coeff_c_q[31:16]);
	assign md  = bpc_pkg::sx16(coeff_c_q[15:0]);

	bpc_pkg::word_t ut, up, b6, tdiv, b3_t, b3_mag, p_sr8, scale;
	assign ut     = bpc_pkg::zx16(raw_q[15:0]);
	assign up     = bpc_pkg::word_t'(raw_q >> (4'd8 - {2'b00, oss_q}));
	assign b6     = b5_q - bpc_pkg::K_4000;
	assign tdiv   = x1_q + md;
	assign b3_t   = (((ac1 << 2) + x3_q) << oss_q) + bpc_pkg::word_t'(2);
	assign b3_mag = bpc_pkg::mag(b3_t) >> 2;
	assign p_sr8  = bpc_pkg::sra(p_q, 5'd8);
	assign scale  = bpc_pkg::word_t'(bpc_pkg::K_50000 >> oss_q);

	// Shared serial units.
	logic mul_start, mul_done, div_start, div_done;
	bpc_pkg::word_t mul_a, mul_b, mul_p, div_n, div_d, div_q;

	bpc_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
	);

	bpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(div_n), .d(div_d), .done(div_done), .q(div_q)
	);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = '0;
		unique case (state_q)
			S_T_X1:  begin mul_a = ut - ac6;     mul_b = ac5; end
			S_T_DIV: begin div_n = bpc_pkg::mag(na_q); div_d = bpc_pkg::mag(tdiv); end
			S_P_SQ:  begin mul_a = b6;           mul_b = b6; end
			S_P_X1:  begin mul_a = b2;           mul_b = sq_q; end
			S_P_X2:  begin mul_a = ac2;          mul_b = b6; end
			S_P_X1B: begin mul_a = ac3;          mul_b = b6; end
			S_P_X2B: begin mul_a = b1;           mul_b = sq_q; end
			S_P_B4:  begin mul_a = ac4;          mul_b = x3_q + bpc_pkg::K_32768; end
			S_P_B7:  begin mul_a = up - b3_q;    mul_b = scale; end
			S_P_DIV: begin
				// With its top bit clear B7 is doubled before the divide, else the quotient is doubled after it.
				div_n = b7_q[bpc_pkg::ARITH_WIDTH-1] ? b7_q : (b7_q << 1);
				div_d = b4_q;
			end
			S_P_F1:  begin mul_a = p_sr8;        mul_b = p_sr8; end
			S_P_F2:  begin mul_a = x1_q;         mul_b = bpc_pkg::K_3038; end
			S_P_F3:  begin mul_a = p_q;          mul_b = bpc_pkg::K_M7357; end
			default: begin end
		endcase
	end

	logic is_mul_state;
	always_comb begin
		case (state_q)
			S_T_X1, S_P_SQ, S_P_X1, S_P_X2, S_P_X1B, S_P_X2B, S_P_B4, S_P_B7,
			S_P_F1, S_P_F2, S_P_F3: is_mul_state = 1'b1;
			default:                is_mul_state = 1'b0;
		endcase
	end
	assign mul_start = is_mul_state && !op_busy_q;
	assign div_start = (state_q == S_T_DIV || state_q == S_P_DIV) && !op_busy_q;

	logic op_done;
	assign op_done = op_busy_q && (mul_done || div_done);

	// Quotient of the temperature divide with the sign restored.
	bpc_pkg::word_t t_x2, t_nb5, f3_x2;
	assign t_x2  = (na_q[bpc_pkg::ARITH_WIDTH-1] ^ tdiv[bpc_pkg::ARITH_WIDTH-1])
		? bpc_pkg::word_t'(-div_q) : div_q;
	assign t_nb5 = x1_q + t_x2;
	assign f3_x2 = bpc_pkg::sra(mul_p, 5'd16);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_busy_q   <= 1'b0;
			coeff_a_q   <= '0;
			coeff_b_q   <= '0;
			coeff_c_q   <= '0;
			oss_q       <= 2'd3;
			b5_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					bpc_pkg::CFG_COEFF_A: coeff_a_q <= cfg_data;
					bpc_pkg::CFG_COEFF_B: coeff_b_q <= cfg_data;
					bpc_pkg::CFG_COEFF_C: coeff_c_q <= cfg_data[31:0];
					bpc_pkg::CFG_OSS:     oss_q     <= cfg_data[1:0];
					default: begin end
				endcase
			end

			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			if (mul_start || div_start)
				op_busy_q <= 1'b1;
			else if (op_done)
				op_busy_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q    <= mode;
						raw_q     <= raw_reading;
						res_err_q <= 1'b0;
						res_val_q <= '0;
						state_q   <= (mode == bpc_pkg::MODE_PRESS) ? S_P_SQ : S_T_X1;
					end
				end
				S_T_X1: if (op_done) begin
					x1_q    <= bpc_pkg::sra(mul_p, 5'd15);
					state_q <= S_T_CHK;
				end
				S_T_CHK: begin
					na_q <= mc << 11;
					if (tdiv == '0) begin
						res_err_q <= 1'b1;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_T_DIV;
					end
				end
				S_T_DIV: if (op_done) begin
					b5_q      <= t_nb5;
					res_val_q <= bpc_pkg::sra(t_nb5 + bpc_pkg::word_t'(8), 5'd4);
					state_q   <= S_DONE;
				end
				S_P_SQ: if (op_done) begin
					sq_q    <= bpc_pkg::sra(mul_p, 5'd12);
					state_q <= S_P_X1;
				end
				S_P_X1: if (op_done) begin
					x1_q    <= bpc_pkg::sra(mul_p, 5'd11);
					state_q <= S_P_X2;
				end
				S_P_X2: if (op_done) begin
					x3_q    <= x1_q + bpc_pkg::sra(mul_p, 5'd11);
					state_q <= S_P_B3;
				end
				S_P_B3: begin
					// B3 divides by four with truncation toward zero.
					b3_q    <= b3_t[bpc_pkg::ARITH_WIDTH-1] ? bpc_pkg::word_t'(-b3_mag) : b3_mag;
					state_q <= S_P_X1B;
				end
				S_P_X1B: if (op_done) begin
					x1_q    <= bpc_pkg::sra(mul_p, 5'd13);
					state_q <= S_P_X2B;
				end
				S_P_X2B: if (op_done) begin
					x3_q    <= bpc_pkg::sra(x1_q + bpc_pkg::sra(mul_p, 5'd16)
						+ bpc_pkg::word_t'(2), 5'd2);
					state_q <= S_P_B4;
				end
				S_P_B4: if (op_done) begin
					b4_q    <= mul_p >> 15;
					state_q <= S_P_B7;
				end
				S_P_B7: if (op_done) begin
					b7_q <= mul_p;
					if (b4_q == '0) begin
						res_err_q <= 1'b1;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_P_DIV;
					end
				end
				S_P_DIV: if (op_done) begin
					p_q     <= b7_q[bpc_pkg::ARITH_WIDTH-1] ? (div_q << 1) : div_q;
					state_q <= S_P_F1;
				end
				S_P_F1: if (op_done) begin
					x1_q    <= mul_p;
					state_q <= S_P_F2;
				end
				S_P_F2: if (op_done) begin
					x1_q    <= bpc_pkg::sra(mul_p, 5'd16);
					state_q <= S_P_F3;
				end
				S_P_F3: if (op_done) begin
					res_val_q <= p_q + bpc_pkg::sra(x1_q + f3_x2 + bpc_pkg::K_3791, 5'd4);
					state_q   <= S_DONE;
				end
				S_DONE: begin
					// Hand the result over once the output register is free.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						kind_q      <= mode_q;
						value_q     <= res_val_q[31:0];
						err_q       <= res_err_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign value        = value_q;
	assign divide_error = err_q;

endmodule

@@ design/bpc_checker.sv @@
module bpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        mode,
	input logic [23:0] raw_reading,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [31:0] value,
	input logic        divide_error,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [63:0] cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(kind))
		else $error("result beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_error |-> value == 32'd0)
		else $error("divide error with nonzero value");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !(out_valid && out_ready && $past(!out_valid)))
		else $error("input taken while an item is in work");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);
